// ===== hdl/heartbeat_arrival_failure_detector_assert.svh =====
// Assertion macros for the heartbeat failure detector.
`ifndef HEARTBEAT_ARRIVAL_FAILURE_DETECTOR_ASSERT_SVH
`define HEARTBEAT_ARRIVAL_FAILURE_DETECTOR_ASSERT_SVH
`ifndef SYNTH
`define HAFD_CHECK(lbl, prop) lbl: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error("hafd check failed");
`define HAFD_NEVER(lbl, cond) lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
   else $error("hafd forbidden condition seen");
`else
`define HAFD_CHECK(lbl, prop)
`define HAFD_NEVER(lbl, cond)
`endif
`endif

// ===== hdl/hafd_pkg.sv =====
package hafd_pkg;

   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_BEAT,
      KIND_TICK
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] seq;
      logic [63:0] stamp;
   } item_type;

   localparam logic [1:0] VERDICT_PASS = 2'd0;
   localparam logic [1:0] VERDICT_DROP = 2'd1;
   localparam logic [1:0] VERDICT_TICK = 2'd2;

   localparam logic [15:0] MIN_FRAME_LEN  = 16'd50;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   localparam logic [15:0] PORT_RESET     = 16'd8888;
   localparam logic [31:0] INTERVAL_RESET = 32'd1000000000;

   localparam logic CSR_IDX_PORT     = 1'b0;
   localparam logic CSR_IDX_INTERVAL = 1'b1;

endpackage

// ===== hdl/hafd_front.sv =====
module hafd_front import hafd_pkg::*; (
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_frame_length,
   input  logic [15:0] req_ethertype,
   input  logic [7:0]  req_ip_protocol,
   input  logic [15:0] req_udp_dest_port,
   input  logic [31:0] req_sequence_req,
   input  logic [63:0] req_time_ns,
   input  logic [15:0] beat_port,
   input  logic        queue_full,
   output logic        push,
   output item_type    push_item
);

   logic is_beat;

   assign is_beat = (req_frame_length >= MIN_FRAME_LEN) && (req_ethertype == ETHERTYPE_IPV4) &&
                    (req_ip_protocol == PROTO_UDP) && (req_udp_dest_port == beat_port);

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.seq   = req_sequence_req;
      push_item.stamp = req_time_ns;
      if (req_op) begin
         push_item.kind = KIND_TICK;
      end else if (is_beat) begin
         push_item.kind = KIND_BEAT;
      end else begin
         push_item.kind = KIND_PASS;
      end
   end

endmodule

// ===== hdl/hafd_queue.sv =====
module hafd_queue import hafd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   output logic     head_valid,
   output item_type head_item,
   input  logic     pop
);

   // Two slots; slot 0 is always the head.
   item_type   slot0_ff, slot0_in;
   item_type   slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;
   logic [1:0] base;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot0_ff;
   assign do_pop     = pop && head_valid;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (do_pop) begin
         slot0_in = slot1_ff;
      end
      base = count_ff - {1'b0, do_pop};
      if (push) begin
         if (base == 2'd0) begin
            slot0_in = push_item;
         end else begin
            slot1_in = push_item;
         end
      end
      count_in = base + {1'b0, push};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== hdl/hafd_div.sv =====
module hafd_div #(
   parameter int DW = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [63:0]   quotient
);

   // Restoring division, one quotient bit per cycle; quotient bits shift
   // into the dividend register as its upper bits leave.
   logic [63:0]   dvd_ff, dvd_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted;
   logic          fits;

   assign done     = done_ff;
   assign quotient = dvd_ff;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, dvd_ff[63]};
      fits    = shifted >= {1'b0, dsr_ff};
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DW'(shifted - {1'b0, dsr_ff}) : DW'(shifted);
         dvd_in = {dvd_ff[62:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ===== hdl/hafd_back.sv =====
module hafd_back import hafd_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] interval_ns,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_accepted,
   output logic        rsp_suspect,
   output logic [63:0] rsp_estimate
);

   localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW = $clog2(WINDOW + 1);
   // Reciprocal of the window; the estimate it gives is low by at most one.
   localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / 64'(WINDOW);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MEAN_A,
      S_MEAN_B,
      S_MEAN_C,
      S_SLIDE_A,
      S_SLIDE_B,
      S_SLIDE_C,
      S_SLIDE_D,
      S_SLIDE_E,
      S_SLIDE_F
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] ls_ff, ls_in;
   logic [63:0] rm_ff, rm_in;
   logic [63:0] ea_ff, ea_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic        armed_ff, armed_in;
   logic [63:0] t_ff, t_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [127:0] wide_ff, wide_in;
   logic [CW-1:0] dsr_ff, dsr_in;
   logic        empty_ff, empty_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  verdict_ff, verdict_in;
   logic        accepted_ff, accepted_in;
   logic        suspect_ff, suspect_in;
   logic [63:0] estimate_ff, estimate_in;

   logic [63:0] ring [WINDOW];
   logic [63:0] rdata_ff;
   logic        ring_we;
   logic        ring_re;
   logic [63:0] ring_wdata;
   logic [PW:0] rd_sum;
   logic [PW-1:0] rd_addr;
   logic [PW-1:0] wp_next;
   logic [CW-1:0] fill_push;
   logic [CW-1:0] s_low;
   logic [CW-1:0] s_plus;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;
   logic [63:0] q_est;
   logic [63:0] slide_rem;
   logic [63:0] q_fix;

   logic        div_start;
   logic [63:0] div_dividend;
   logic [CW-1:0] div_divisor;
   logic        div_done;
   logic [63:0] div_quotient;

   hafd_div #(.DW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_verdict  = verdict_ff;
   assign rsp_accepted = accepted_ff;
   assign rsp_suspect  = suspect_ff;
   assign rsp_estimate = estimate_ff;

   assign s_low     = head_item.seq[CW-1:0];
   assign s_plus    = s_low + CW'(1);
   assign wp_next   = (wp_ff == PW'(WINDOW - 1)) ? '0 : wp_ff + PW'(1);
   assign fill_push = (fill_ff < CW'(WINDOW)) ? fill_ff + CW'(1) : fill_ff;

   // Oldest entry sits fill places behind the write pointer.
   assign rd_sum  = (PW+1)'(wp_ff) + (PW+1)'(WINDOW) - (PW+1)'(fill_ff);
   assign rd_addr = (rd_sum >= (PW+1)'(WINDOW)) ? PW'(rd_sum - (PW+1)'(WINDOW))
                                                : PW'(rd_sum);

   // One 32x32 multiplier builds the difference times the reciprocal from four
   // partial products; a compare and an increment then fix the quotient.
   assign mul_p     = mul_a * mul_b;
   assign q_est     = wide_ff[127:64];
   assign slide_rem = prod_ff - q_est * 64'(WINDOW);
   assign q_fix     = (slide_rem >= 64'(WINDOW)) ? q_est + 64'd1 : q_est;

   always_comb begin
      state_in     = state_ff;
      ls_in        = ls_ff;
      rm_in        = rm_ff;
      ea_in        = ea_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      armed_in     = armed_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      wide_in      = wide_ff;
      dsr_in       = dsr_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff;
      verdict_in   = verdict_ff;
      accepted_in  = accepted_ff;
      suspect_in   = suspect_ff;
      estimate_in  = estimate_ff;
      pop          = 1'b0;
      ring_we      = 1'b0;
      ring_re      = 1'b0;
      ring_wdata   = head_item.stamp;
      div_start    = 1'b0;
      div_dividend = head_item.stamp;
      div_divisor  = s_plus;
      mul_a        = prod_ff[31:0];
      mul_b        = RECIP[31:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (head_valid && !rsp_valid_ff) begin
               pop         = 1'b1;
               accepted_in = 1'b0;
               suspect_in  = 1'b0;
               estimate_in = ea_ff;
               case (head_item.kind)
                  KIND_TICK: begin
                     verdict_in   = VERDICT_TICK;
                     rsp_valid_in = 1'b1;
                     if (armed_ff && (head_item.stamp >= ea_ff)) begin
                        suspect_in = 1'b1;
                        armed_in   = 1'b0;
                     end
                  end
                  KIND_BEAT: begin
                     verdict_in = VERDICT_DROP;
                     if (head_item.seq < ls_ff) begin
                        rsp_valid_in = 1'b1;
                     end else if (head_item.seq == 32'd0) begin
                        ring_we      = 1'b1;
                        wp_in        = wp_next;
                        fill_in      = fill_push;
                        rm_in        = head_item.stamp;
                        ea_in        = head_item.stamp + 64'(interval_ns >> 1);
                        armed_in     = 1'b1;
                        accepted_in  = 1'b1;
                        estimate_in  = ea_in;
                        rsp_valid_in = 1'b1;
                     end else if (head_item.seq < 32'(WINDOW)) begin
                        ring_we   = 1'b1;
                        wp_in     = wp_next;
                        fill_in   = fill_push;
                        ls_in     = head_item.seq;
                        prod_in   = rm_ff * 64'(s_low);
                        dsr_in    = s_plus;
                        div_start = 1'b1;
                        state_in  = S_MEAN_A;
                     end else begin
                        // Read the oldest arrival now; the new arrival is written at the write pointer next cycle.
                        ring_re  = 1'b1;
                        empty_in = (fill_ff == '0);
                        fill_in  = (fill_ff == '0) ? CW'(1) : fill_ff;
                        ls_in    = head_item.seq;
                        t_in     = head_item.stamp;
                        state_in = S_SLIDE_A;
                     end
                  end
                  default: begin
                     verdict_in   = VERDICT_PASS;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_MEAN_A: begin
            div_dividend = prod_ff;
            div_divisor  = dsr_ff;
            if (div_done) begin
               acc_in    = div_quotient;
               div_start = 1'b1;
               state_in  = S_MEAN_B;
            end
         end
         S_MEAN_B: begin
            if (div_done) begin
               rm_in    = acc_ff + div_quotient;
               state_in = S_MEAN_C;
            end
         end
         S_MEAN_C: begin
            ea_in        = rm_ff + 64'((40'(dsr_ff) * 40'(interval_ns)) >> 1);
            armed_in     = 1'b1;
            accepted_in  = 1'b1;
            estimate_in  = ea_in;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SLIDE_A: begin
            ring_we    = 1'b1;
            ring_wdata = t_ff;
            wp_in      = wp_next;
            prod_in    = t_ff - (empty_ff ? 64'd0 : rdata_ff);
            state_in   = S_SLIDE_B;
         end
         S_SLIDE_B: begin
            wide_in  = {64'd0, mul_p};
            state_in = S_SLIDE_C;
         end
         S_SLIDE_C: begin
            mul_a    = prod_ff[63:32];
            wide_in  = wide_ff + {32'd0, mul_p, 32'd0};
            state_in = S_SLIDE_D;
         end
         S_SLIDE_D: begin
            mul_b    = RECIP[63:32];
            wide_in  = wide_ff + {32'd0, mul_p, 32'd0};
            state_in = S_SLIDE_E;
         end
         S_SLIDE_E: begin
            mul_a    = prod_ff[63:32];
            mul_b    = RECIP[63:32];
            wide_in  = wide_ff + {mul_p, 64'd0};
            state_in = S_SLIDE_F;
         end
         S_SLIDE_F: begin
            ea_in        = ea_ff + q_fix;
            armed_in     = 1'b1;
            accepted_in  = 1'b1;
            estimate_in  = ea_in;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ls_ff        <= '0;
         rm_ff        <= '0;
         ea_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ls_ff        <= ls_in;
         rm_ff        <= rm_in;
         ea_ff        <= ea_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff        <= t_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      wide_ff     <= wide_in;
      dsr_ff      <= dsr_in;
      empty_ff    <= empty_in;
      verdict_ff  <= verdict_in;
      accepted_ff <= accepted_in;
      suspect_ff  <= suspect_in;
      estimate_ff <= estimate_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[wp_ff] <= ring_wdata;
      end
      if (ring_re) begin
         rdata_ff <= ring[rd_addr];
      end
   end

endmodule

// ===== hdl/heartbeat_arrival_failure_detector.sv =====
// A passed frame, tick, stale heartbeat or sequence-0 heartbeat is answered from S_IDLE;
// rsp_valid is registered as the back end pops it. A heartbeat below the window steps
// through S_MEAN_A to S_MEAN_C, with two passes of the one-bit-per-cycle divider for the
// running mean; a later heartbeat steps through S_SLIDE_A to S_SLIDE_F (reciprocal
// multiply in four 32-bit partial products). The back end takes one request at a time.
// Reset (synchronous, active high) clears the estimator, ring pointers and deadline and
// loads the default port and interval; ring contents are not cleared.
`include "heartbeat_arrival_failure_detector_assert.svh"
module heartbeat_arrival_failure_detector import hafd_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_frame_length,
   input  logic [15:0] req_ethertype,
   input  logic [7:0]  req_ip_protocol,
   input  logic [15:0] req_udp_dest_port,
   input  logic [31:0] req_sequence_req,
   input  logic [63:0] req_time_ns,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_accepted,
   output logic        rsp_suspect,
   output logic [63:0] rsp_estimate,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] port_ff, port_in;
   logic [31:0] interval_ff, interval_in;
   logic        csr_write;
   logic        queue_full;
   logic        push;
   item_type    push_item;
   logic        head_valid;
   item_type    head_item;
   logic        pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_INTERVAL) ? interval_ff : {16'd0, port_ff};

   always_comb begin
      port_in     = port_ff;
      interval_in = interval_ff;
      if (csr_write) begin
         if (csr_paddr[2] == CSR_IDX_PORT) begin
            port_in = csr_pwdata[15:0];
         end else begin
            interval_in = csr_pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff     <= PORT_RESET;
         interval_ff <= INTERVAL_RESET;
      end else begin
         port_ff     <= port_in;
         interval_ff <= interval_in;
      end
   end

   hafd_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_frame_length  (req_frame_length),
      .req_ethertype     (req_ethertype),
      .req_ip_protocol   (req_ip_protocol),
      .req_udp_dest_port (req_udp_dest_port),
      .req_sequence_req  (req_sequence_req),
      .req_time_ns       (req_time_ns),
      .beat_port         (port_ff),
      .queue_full        (queue_full),
      .push              (push),
      .push_item         (push_item)
   );

   hafd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   hafd_back #(.WINDOW(WINDOW)) u_back (
      .clock        (clock),
      .reset        (reset),
      .interval_ns  (interval_ff),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_verdict  (rsp_verdict),
      .rsp_accepted (rsp_accepted),
      .rsp_suspect  (rsp_suspect),
      .rsp_estimate (rsp_estimate)
   );

   `HAFD_CHECK(a_accept_is_drop, rsp_valid && rsp_accepted |-> rsp_verdict == VERDICT_DROP)
   `HAFD_CHECK(a_suspect_on_tick, rsp_valid && rsp_suspect |-> rsp_verdict == VERDICT_TICK)
   `HAFD_CHECK(a_interval_write, csr_write && csr_paddr[2] |=> interval_ff == $past(csr_pwdata))
   `HAFD_NEVER(a_push_when_full, push && queue_full)

endmodule
